/* hdl/dd_pkg.sv */
`default_nettype none

package dd_pkg;

  // Field widths fixed by the date formats.
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OrdW   = 22;
  localparam int unsigned DiffW  = 23;
  localparam int unsigned CentW  = 8;
  localparam int unsigned CumW   = 9;

  localparam int unsigned YearMax = 9999;

  // floor(x / 100) == (x * Div100Mul) >> Div100Shift for every x below 2**14.
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = YearW + 13;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Days in a month of a common year; 0 for a month code outside the calendar.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [CumW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [CumW-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/dd_in_if.sv */
`default_nettype none

interface dd_in_if;
  logic                        valid;
  logic                        ready;
  logic [dd_pkg::YearW-1:0]    start_year;
  logic [dd_pkg::MonthW-1:0]   start_month;
  logic [dd_pkg::DayW-1:0]     start_day;
  logic [dd_pkg::YearW-1:0]    end_year;
  logic [dd_pkg::MonthW-1:0]   end_month;
  logic [dd_pkg::DayW-1:0]     end_day;
  logic                        count_end_day;

  modport source (
    output valid, start_year, start_month, start_day,
    output end_year, end_month, end_day, count_end_day,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day,
    input  end_year, end_month, end_day, count_end_day,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/dd_out_if.sv */
`default_nettype none

interface dd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dd_pkg::DiffW-1:0]   day_difference;
  logic                              date_error;

  modport source (
    output valid, day_difference, date_error,
    input  ready
  );

  modport sink (
    input  valid, day_difference, date_error,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/date_difference_days.sv */
// Gregorian date difference: each request carries a start date, an end date
// (years 1 to 9999) and a count_end_day flag, and yields one result with the
// signed number of days from start to end; the end day is added to the
// magnitude before the sign when the flag is set. An invalid year, month or
// day in either date gives date_error set and a difference of 0. The block
// is a four-stage pipeline that accepts one request every cycle until a
// stall at the output has filled every stage. Each request passes through
// the stage chain (century split, year and month tables, ordinal sum,
// subtraction) into the output register. A stall at the output fills the
// empty stages first, so up to four requests are held before ready drops.
`default_nettype none

module date_difference_days (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dd_in_if.sink     req_i,
  dd_out_if.source  rsp_o
);

  // Valid bits of the three ordinal stages and of the output register.
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4;
  dd_pkg::stage_en_t en;

  // A stage loads whenever it is empty or its contents move on.
  always_comb begin
    rdy4  = !vo_q || rsp_o.ready;
    rdy3  = !v3_q || rdy4;
    rdy2  = !v2_q || rdy3;
    rdy1  = !v1_q || rdy2;
    en.s1 = rdy1;
    en.s2 = rdy2;
    en.s3 = rdy3;
  end

  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) vo_q <= v3_q;
    end
  end

  // The end-day flag travels beside the ordinal stages.
  logic inc1_q, inc2_q, inc3_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) inc1_q <= req_i.count_end_day;
    if (rdy2) inc2_q <= inc1_q;
    if (rdy3) inc3_q <= inc2_q;
  end

  logic [dd_pkg::OrdW-1:0] start_ord, end_ord;
  logic                    start_ok, end_ok;

  dd_date_ord u_start_ord (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (req_i.start_year),
    .month_i   (req_i.start_month),
    .day_i     (req_i.start_day),
    .ordinal_o (start_ord),
    .date_ok_o (start_ok)
  );

  dd_date_ord u_end_ord (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (req_i.end_year),
    .month_i   (req_i.end_month),
    .day_i     (req_i.end_day),
    .ordinal_o (end_ord),
    .date_ok_o (end_ok)
  );

  dd_diff u_diff (
    .clk_i            (clk_i),
    .en_i             (rdy4),
    .start_ord_i      (start_ord),
    .end_ord_i        (end_ord),
    .start_ok_i       (start_ok),
    .end_ok_i         (end_ok),
    .count_end_day_i  (inc3_q),
    .day_difference_o (rsp_o.day_difference),
    .date_error_o     (rsp_o.date_error)
  );

  assign rsp_o.valid = vo_q;

  // Ready drops only when every stage holds a request.
  a_full_when_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled while the pipeline has a free stage");

  // An erroneous result always carries a zero difference.
  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.date_error) |-> (rsp_o.day_difference == '0))
    else $error("date error with nonzero difference");

  // A held last ordinal stage keeps its request until the output frees up.
  a_stage3_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(start_ord) && $stable(end_ord)))
    else $error("stalled stage lost its request");

  // An accepted request reaches stage 1 in the next cycle.
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v1_q)
    else $error("accepted request did not enter the pipeline");

endmodule

`default_nettype wire

/* hdl/dd_date_ord.sv */
`default_nettype none

// Three-stage ordinal day number of one date, with a validity flag.
module dd_date_ord (
  input  wire logic                        clk_i,
  input  wire dd_pkg::stage_en_t           en_i,
  input  wire logic [dd_pkg::YearW-1:0]    year_i,
  input  wire logic [dd_pkg::MonthW-1:0]   month_i,
  input  wire logic [dd_pkg::DayW-1:0]     day_i,
  output logic      [dd_pkg::OrdW-1:0]     ordinal_o,
  output logic                             date_ok_o
);

  // Stage 1: previous year and centuries of both years.
  logic [dd_pkg::YearW-1:0]  y1_d, y1_q, py1_d, py1_q;
  logic [dd_pkg::CentW-1:0]  qy1_d, qy1_q, qp1_d, qp1_q;
  logic [dd_pkg::MonthW-1:0] m1_q;
  logic [dd_pkg::DayW-1:0]   d1_q;
  logic                      yok1_d, yok1_q;
  logic [dd_pkg::ProdW-1:0]  prod_y, prod_p;

  always_comb begin
    y1_d   = year_i;
    py1_d  = year_i - dd_pkg::YearW'(1);
    prod_y = dd_pkg::ProdW'(year_i) * dd_pkg::ProdW'(dd_pkg::Div100Mul);
    prod_p = dd_pkg::ProdW'(py1_d) * dd_pkg::ProdW'(dd_pkg::Div100Mul);
    qy1_d  = prod_y[dd_pkg::Div100Shift +: dd_pkg::CentW];
    qp1_d  = prod_p[dd_pkg::Div100Shift +: dd_pkg::CentW];
    yok1_d = (year_i != '0) && (year_i <= dd_pkg::YearW'(dd_pkg::YearMax));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      y1_q   <= y1_d;
      py1_q  <= py1_d;
      qy1_q  <= qy1_d;
      qp1_q  <= qp1_d;
      m1_q   <= month_i;
      d1_q   <= day_i;
      yok1_q <= yok1_d;
    end
  end

  // Stage 2: leap year, validity, days in whole years and whole months.
  logic [dd_pkg::YearW-1:0]  rem100;
  logic                      leap;
  logic [dd_pkg::DayW-1:0]   dim;
  logic [dd_pkg::OrdW-1:0]   yd2_d, yd2_q;
  logic [dd_pkg::CumW-1:0]   cum2_d, cum2_q;
  logic [dd_pkg::DayW-1:0]   d2_q;
  logic                      ok2_d, ok2_q;

  always_comb begin
    rem100 = y1_q - dd_pkg::YearW'(16'(qy1_q) * 16'd100);
    leap   = ((y1_q[1:0] == 2'b00) && (rem100 != '0)) ||
             ((rem100 == '0) && (qy1_q[1:0] == 2'b00));
    dim    = dd_pkg::month_len(m1_q);
    if ((m1_q == dd_pkg::MonthFeb) && leap) begin
      dim = dim + dd_pkg::DayW'(1);
    end
    ok2_d  = yok1_q && (dim != '0) && (d1_q != '0) && (d1_q <= dim);
    cum2_d = dd_pkg::days_before(m1_q) +
             dd_pkg::CumW'(leap && (m1_q > dd_pkg::MonthFeb));
    yd2_d  = dd_pkg::OrdW'(py1_q) * dd_pkg::OrdW'(365)
           + dd_pkg::OrdW'(py1_q >> 2)
           - dd_pkg::OrdW'(qp1_q)
           + dd_pkg::OrdW'(qp1_q >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      yd2_q  <= yd2_d;
      cum2_q <= cum2_d;
      d2_q   <= d1_q;
      ok2_q  <= ok2_d;
    end
  end

  // Stage 3: ordinal day number.
  logic [dd_pkg::OrdW-1:0] ord3_q;
  logic                    ok3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ord3_q <= yd2_q + dd_pkg::OrdW'(cum2_q) + dd_pkg::OrdW'(d2_q);
      ok3_q  <= ok2_q;
    end
  end

  assign ordinal_o = ord3_q;
  assign date_ok_o = ok3_q;

endmodule

`default_nettype wire

/* hdl/dd_diff.sv */
`default_nettype none

// Final stage: signed difference of two ordinal day numbers.
module dd_diff (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [dd_pkg::OrdW-1:0]     start_ord_i,
  input  wire logic [dd_pkg::OrdW-1:0]     end_ord_i,
  input  wire logic                        start_ok_i,
  input  wire logic                        end_ok_i,
  input  wire logic                        count_end_day_i,
  output logic signed [dd_pkg::DiffW-1:0]  day_difference_o,
  output logic                             date_error_o
);

  logic [dd_pkg::DiffW-1:0] fwd, bwd, res_d;
  logic signed [dd_pkg::DiffW-1:0] res_q;
  logic err_d, err_q;

  always_comb begin
    fwd = dd_pkg::DiffW'(end_ord_i) - dd_pkg::DiffW'(start_ord_i)
        + dd_pkg::DiffW'(count_end_day_i);
    bwd = dd_pkg::DiffW'(start_ord_i) - dd_pkg::DiffW'(end_ord_i)
        + dd_pkg::DiffW'(count_end_day_i);
    err_d = !(start_ok_i && end_ok_i);
    if (err_d) begin
      res_d = '0;
    end else if (end_ord_i < start_ord_i) begin
      res_d = '0 - bwd;
    end else begin
      res_d = fwd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= signed'(res_d);
      err_q <= err_d;
    end
  end

  assign day_difference_o = res_q;
  assign date_error_o     = err_q;

endmodule

`default_nettype wire
